// File: rtl/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg: shared types and constants for the exact substring search unit
// Field widths, function codes and the structs passed between the submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package ess_pkg;

	localparam int PAT_MAX_DEF = 64;  // default pattern capacity in bytes
	localparam int CFG_W       = 7;   // pat_len register width
	localparam int PIDX_W      = 6;   // pat_index field width
	localparam int BYTE_W      = 8;   // data_byte width
	localparam int POS_W       = 32;  // match_pos and byte counter width
	localparam int CMP_W       = 9;   // common width for length compares (PAT_MAX <= 511)

	typedef enum logic {
		FUNC_PAT_WRITE = 1'b0,
		FUNC_TARGET    = 1'b1
	} func_t;

	// control for one step of the match core
	typedef struct packed {
		logic step;   // a target byte is processed this cycle
		logic last;   // that byte ends the search
	} step_ctrl_t;

	// result produced by the match core for the current step
	typedef struct packed {
		logic             emit;   // a result transaction is produced
		logic             found;
		logic [POS_W-1:0] pos;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/ess_pattern_store.sv
// ----------------------------------------------------------------------------
// ess_pattern_store: pattern byte registers with per-position comparators
// Holds one byte per pattern position and compares all of them against the
// current target byte in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_pattern_store #(
	parameter int PAT_MAX = ess_pkg::PAT_MAX_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [$clog2(PAT_MAX)-1:0] wr_idx,
	input  wire logic [ess_pkg::BYTE_W-1:0] wr_data,
	input  wire logic [ess_pkg::BYTE_W-1:0] cmp_byte,
	output logic      [PAT_MAX-1:0]         eq
);
	import ess_pkg::*;

	logic [BYTE_W-1:0] pat_q [PAT_MAX];

	// no reset: entries are undefined until written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q[wr_idx] <= wr_data;
		end
	end

	always_comb begin
		for (int k = 0; k < PAT_MAX; k++) begin
			eq[k] = (pat_q[k] == cmp_byte);
		end
	end

endmodule

`default_nettype wire

// File: rtl/ess_match_core.sv
// ----------------------------------------------------------------------------
// ess_match_core: shift-and partial match vector and search bookkeeping
// Advances the prefix-match vector one target byte per step, counts bytes,
// and decides when a found or not-found result is produced.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_match_core #(
	parameter int PAT_MAX = ess_pkg::PAT_MAX_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ess_pkg::step_ctrl_t        ctrl,
	input  wire logic [PAT_MAX-1:0]         eq,
	input  wire logic [$clog2(PAT_MAX)-1:0] hit_idx,
	output ess_pkg::result_t                res
);
	import ess_pkg::*;

	logic [PAT_MAX-1:0] pm_q;
	logic [PAT_MAX-1:0] pm_n;
	logic [POS_W-1:0]   count_q;
	logic               reported_q;
	logic               hit;

	always_comb begin
		// prefix k matches if prefix k-1 matched on the previous byte
		pm_n = {pm_q[PAT_MAX-2:0], 1'b1} & eq;
		hit  = pm_n[hit_idx];
		res.emit  = ctrl.step && !reported_q && (hit || ctrl.last);
		res.found = hit;
		res.pos   = hit ? (count_q - POS_W'(hit_idx)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q       <= '0;
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (ctrl.step) begin
			if (ctrl.last) begin
				pm_q       <= '0;
				count_q    <= '0;
				reported_q <= 1'b0;
			end else begin
				pm_q       <= pm_n;
				reported_q <= reported_q | hit;
				if (count_q != '1) begin
					count_q <= count_q + POS_W'(1);
				end
			end
		end
	end

	// a search that ends always leaves a clean state behind
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step && ctrl.last |=> (count_q == '0) && (pm_q == '0) && !reported_q)
		else $error("search state not cleared after last byte");

	// once a match was reported, nothing more comes out in this search
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		reported_q |-> !res.emit)
		else $error("second result within one search");

endmodule

`default_nettype wire

// File: rtl/exact_substring_search_unit.sv
// Timing: a transaction waits in the input register until the output register
//   can take a result; its result is on the output port in the cycle after it leaves.
// Throughput: one transaction per cycle while no result waits stalled in the
//   output register.
// Reset: arst_n clears the match state, byte count, pat_len (to 1) and the
//   valid flags; pattern bytes are undefined until written.
// ----------------------------------------------------------------------------
// exact_substring_search_unit: streaming first-occurrence substring search
// Pattern bytes load by index; target bytes stream through a shift-and
// matcher that reports the first match offset or not-found at the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module exact_substring_search_unit #(
	parameter int PAT_MAX = ess_pkg::PAT_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: pattern length
	input  wire logic                        cfg_we,
	input  wire logic [ess_pkg::CFG_W-1:0]   cfg_wdata,
	// input channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        func,
	input  wire logic [ess_pkg::PIDX_W-1:0]  pat_index,
	input  wire logic [ess_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                        is_last,
	// output channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             found,
	output logic [ess_pkg::POS_W-1:0]        match_pos
);
	import ess_pkg::*;

	localparam int IDX_W = $clog2(PAT_MAX);

	// configuration register
	logic [CFG_W-1:0] pat_len_q;

	// input register stage
	logic              valid_s1;
	func_t             func_s1;
	logic [PIDX_W-1:0] pat_index_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              is_last_s1;

	// output register
	logic              out_valid_q;
	logic              found_q;
	logic [POS_W-1:0]  match_pos_q;

	logic               advance;
	logic               pat_wr_en;
	logic [CMP_W-1:0]   len_ext;
	logic [IDX_W-1:0]   hit_idx;
	logic [PAT_MAX-1:0] eq;
	step_ctrl_t         ctrl;
	result_t            res;

	// The held transaction is consumed when the output register can take a
	// result: either it is empty or its transaction completes this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= CFG_W'(1);
		end else if (cfg_we) begin
			pat_len_q <= cfg_wdata;
		end
	end

	// Capture a new transaction whenever the stage is free or drains now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1      <= func_t'(func);
			pat_index_s1 <= pat_index;
			data_byte_s1 <= data_byte;
			is_last_s1   <= is_last;
		end
	end

	// Effective length: zero acts as one, anything above capacity is clamped.
	// Work with the index of the last prefix bit directly.
	assign len_ext = CMP_W'(pat_len_q);

	always_comb begin
		if (len_ext == '0) begin
			hit_idx = '0;
		end else if (len_ext > CMP_W'(PAT_MAX)) begin
			hit_idx = IDX_W'(PAT_MAX - 1);
		end else begin
			hit_idx = IDX_W'(len_ext - CMP_W'(1));
		end
	end

	// Drop pattern writes that land beyond the store.
	assign pat_wr_en = advance && (func_s1 == FUNC_PAT_WRITE) &&
		(CMP_W'(pat_index_s1) < CMP_W'(PAT_MAX));

	ess_pattern_store #(
		.PAT_MAX (PAT_MAX)
	) u_store (
		.clk      (clk),
		.wr_en    (pat_wr_en),
		.wr_idx   (IDX_W'(pat_index_s1)),
		.wr_data  (data_byte_s1),
		.cmp_byte (data_byte_s1),
		.eq       (eq)
	);

	assign ctrl = '{step: advance && (func_s1 == FUNC_TARGET), last: is_last_s1};

	ess_match_core #(
		.PAT_MAX (PAT_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.eq      (eq),
		.hit_idx (hit_idx),
		.res     (res)
	);

	// Output register: load a new result, otherwise hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			found_q     <= res.found;
			match_pos_q <= res.pos;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign match_pos = match_pos_q;

	// a not-found result always reports offset zero
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_pos == '0)
		else $error("not-found result with nonzero offset");

	// a waiting result must never be overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !res.emit)
		else $error("result emitted while output register is stalled");

	// a stalled held transaction blocks new input
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted while input stage is blocked");

endmodule

`default_nettype wire

// File: tb/ess_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ess_search_checker: scoreboard for the exact substring search unit
// Watches the config port and both channels, predicts each search result with
// a shift-and matcher of its own and compares it with what the block returns.
// ----------------------------------------------------------------------------

module ess_search_checker #(
	parameter int PAT_MAX = ess_pkg::PAT_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ess_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic                        func,
	input  wire logic [ess_pkg::PIDX_W-1:0]  pat_index,
	input  wire logic [ess_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                        is_last,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic                        found,
	input  wire logic [ess_pkg::POS_W-1:0]   match_pos,
	input  wire logic                        drain_check,
	output int                               mismatches,
	output int                               outstanding
);

	typedef struct packed {
		logic                      found;
		logic [ess_pkg::POS_W-1:0] pos;
	} search_result_t;

	search_result_t              expected_results[$];
	search_result_t              want;
	logic [ess_pkg::BYTE_W-1:0]  pattern_bytes[PAT_MAX];
	logic [PAT_MAX-1:0]          prefix_hits;
	logic [ess_pkg::POS_W-1:0]   bytes_seen;
	logic                        match_reported;
	logic [ess_pkg::CFG_W-1:0]   pat_len_reg;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	task automatic clear_search();
		prefix_hits    = '0;
		bytes_seen     = '0;
		match_reported = 1'b0;
	endtask

	// length in use: zero reads as one, oversize clamps to capacity
	function automatic int active_len();
		if (pat_len_reg == '0)
			return 1;
		if (int'(pat_len_reg) > PAT_MAX)
			return PAT_MAX;
		return int'(pat_len_reg);
	endfunction

	task automatic scan_target_byte(input logic [ess_pkg::BYTE_W-1:0] b, input logic last);
		logic [PAT_MAX-1:0]        next_hits;
		logic [ess_pkg::POS_W-1:0] start;
		int                        len;
		int                        k;
		len   = active_len();
		start = bytes_seen;
		next_hits[0] = (pattern_bytes[0] == b);
		for (k = 1; k < PAT_MAX; k++)
			next_hits[k] = prefix_hits[k-1] && (pattern_bytes[k] == b);
		prefix_hits = next_hits;
		if (bytes_seen != '1)
			bytes_seen++;
		if (!match_reported && next_hits[len-1]) begin
			expected_results.push_back('{found: 1'b1, pos: start - ess_pkg::POS_W'(len - 1)});
			if (last)
				clear_search();
			else
				match_reported = 1'b1;
		end else if (last) begin
			// a search that already reported ends silently
			if (!match_reported)
				expected_results.push_back('{found: 1'b0, pos: '0});
			clear_search();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_search();
			pattern_bytes = '{default: '0};
			pat_len_reg   = ess_pkg::CFG_W'(1);
			expected_results.delete();
			mismatches    = 0;
		end else begin
			// retire first: a result never belongs to an item taken at this edge
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result found=%0b pos=%0d",
						found, match_pos));
				end else begin
					want = expected_results.pop_front();
					if (found !== want.found)
						report_mismatch($sformatf("found %0b, want %0b", found, want.found));
					if (match_pos !== want.pos)
						report_mismatch($sformatf("match_pos %0d, want %0d", match_pos,
							want.pos));
				end
			end
			if (cfg_we)
				pat_len_reg = cfg_wdata;
			if (in_valid && in_ready) begin
				if (func == ess_pkg::FUNC_PAT_WRITE) begin
					if (int'(pat_index) < PAT_MAX)
						pattern_bytes[pat_index] = data_byte;
				end else begin
					scan_target_byte(data_byte, is_last);
				end
			end
			if (drain_check && expected_results.size() != 0)
				report_mismatch($sformatf("%0d results never arrived",
					expected_results.size()));
		end
		outstanding = expected_results.size();
	end

endmodule

// File: tb/tb_exact_substring_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exact_substring_search_unit: stimulus and verdict for the search unit
// Loads patterns, streams target bytes through bursty valid/ready traffic with
// a stalling receiver, and leaves prediction and compare to the checker.
// ----------------------------------------------------------------------------

module tb_exact_substring_search_unit;

	import ess_pkg::*;

	localparam int PAT_MAX       = PAT_MAX_DEF;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 480;
	localparam int HOLD_CYCLES   = 160;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_TARGET    = 128;

	// receiver stall patterns
	typedef enum int {
		RX_STEADY,
		RX_COIN,
		RX_MOSTLY,
		RX_EVERY_THIRD
	} rx_mode_e;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                func;
	logic [PIDX_W-1:0]   pat_index;
	logic [BYTE_W-1:0]   data_byte;
	logic                is_last;
	logic                out_valid;
	logic                out_ready;
	logic                found;
	logic [POS_W-1:0]    match_pos;
	logic                drain_check;
	logic                rx_hold_arm;
	logic                rx_hold_done;
	int                  mismatches;
	int                  outstanding;
	int                  cycles = 0;
	int                  burst_left;
	int                  items_sent;
	int                  cur_len;
	logic [BYTE_W-1:0]   pat_image[PAT_MAX];

	exact_substring_search_unit #(
		.PAT_MAX(PAT_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.pat_index(pat_index),
		.data_byte(data_byte),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.match_pos(match_pos)
	);

	ess_search_checker #(
		.PAT_MAX(PAT_MAX)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.pat_index(pat_index),
		.data_byte(data_byte),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.match_pos(match_pos),
		.drain_check(drain_check),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: switch between stall patterns of random length; when armed,
	// take one long hold-off counted here so the block backs up into its input.
	initial begin
		rx_mode_e mode;
		int       mode_left;
		int       hold_left;
		int       phase;
		bit       hold_taken;
		mode       = RX_STEADY;
		mode_left  = 0;
		hold_left  = 0;
		phase      = 0;
		hold_taken = 1'b0;
		out_ready    <= 1'b0;
		rx_hold_done <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
				if (hold_left == 0)
					rx_hold_done <= 1'b1;
			end else if (rx_hold_arm && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_STEADY:  out_ready <= 1'b1;
					RX_COIN:    out_ready <= ($urandom_range(0, 1) == 0);
					RX_MOSTLY:  out_ready <= ($urandom_range(0, 7) != 0);
					default:    out_ready <= (phase % 3 == 0);
				endcase
			end
		end
	end

	// Offer one transaction and hold it until taken. Bursts of random length
	// are separated by random gaps; valid stays high across a burst.
	task automatic send_item(input func_t f, input logic [PIDX_W-1:0] idx,
		input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		in_valid  <= 1'b1;
		func      <= f;
		pat_index <= idx;
		data_byte <= b;
		is_last   <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
	endtask

	// is_last is don't-care on a pattern write; toggle it anyway
	task automatic write_pattern(input int idx, input logic [BYTE_W-1:0] b);
		pat_image[idx] = b;
		send_item(FUNC_PAT_WRITE, PIDX_W'(idx), b, 1'($urandom));
	endtask

	task automatic target_byte(input logic [BYTE_W-1:0] b, input logic last);
		send_item(FUNC_TARGET, PIDX_W'($urandom), b, last);
	endtask

	// Drop valid, wait until every expected result is back, then let the
	// pipeline empty of items that produce no result.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len(input int v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_len = (v == 0) ? 1 : (v > PAT_MAX) ? PAT_MAX : v;
	endtask

	// One search: target bytes drawn mostly from the pattern's own bytes so
	// partial matches pile up, optionally with a full copy planted inside.
	task automatic run_search(input int n, input bit plant, input bit noisy);
		logic [BYTE_W-1:0] tgt[MAX_TARGET];
		int                at;
		int                i;
		for (i = 0; i < n; i++)
			tgt[i] = noisy ? BYTE_W'($urandom) : pat_image[$urandom_range(0, cur_len - 1)];
		if (plant && n >= cur_len) begin
			at = $urandom_range(0, n - cur_len);
			for (i = 0; i < cur_len; i++)
				tgt[at + i] = pat_image[i];
		end
		for (i = 0; i < n; i++) begin
			// now and then rewrite a pattern byte in the middle of the search
			if ($urandom_range(0, 39) == 0)
				write_pattern($urandom_range(0, PAT_MAX - 1), BYTE_W'($urandom));
			target_byte(tgt[i], i == n - 1);
		end
	endtask

	initial begin
		int i;
		int v;
		int r;
		int n;
		int goal;
		int phase_no;
		int searches;
		bit narrow;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		func        <= FUNC_PAT_WRITE;
		pat_index   <= '0;
		data_byte   <= '0;
		is_last     <= 1'b0;
		drain_check <= 1'b0;
		rx_hold_arm <= 1'b0;
		burst_left = 0;
		items_sent = 0;
		cur_len    = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole pattern store first so no search ever compares
		// against a byte that was never written.
		for (i = 0; i < PAT_MAX; i++)
			write_pattern(i, BYTE_W'($urandom));

		// --- directed cases, length still at its reset value of one ---
		write_pattern(0, 8'h00);
		target_byte(8'hFF, 1'b0);
		target_byte(8'h00, 1'b1);          // match on the last byte
		target_byte(8'h00, 1'b0);          // match at offset zero
		target_byte(8'h00, 1'b0);          // bytes after a match stay silent
		target_byte(8'hFF, 1'b1);          // end resets without a result

		write_len(0);                      // zero length behaves as one
		target_byte(8'hFF, 1'b1);

		write_len(3);
		write_pattern(0, 8'hFF);
		write_pattern(1, 8'h00);
		write_pattern(2, 8'hFF);
		target_byte(8'hFF, 1'b0);          // target shorter than the pattern
		target_byte(8'h00, 1'b1);
		target_byte(8'hFF, 1'b0);          // overlapping candidates
		target_byte(8'h00, 1'b0);
		target_byte(8'hFF, 1'b0);
		target_byte(8'h00, 1'b0);
		target_byte(8'hFF, 1'b1);

		write_len(2);
		target_byte(8'hFF, 1'b0);
		write_pattern(1, 8'h7E);           // pattern write mid-search
		target_byte(8'h7E, 1'b1);

		target_byte(8'hFF, 1'b0);
		write_len(1);                      // length change mid-search
		target_byte(8'hFF, 1'b1);

		write_len(127);                    // oversize clamps to capacity
		target_byte(8'h00, 1'b0);
		target_byte(8'hFF, 1'b0);
		target_byte(8'h80, 1'b1);

		// --- back-pressure: one result per byte while the receiver holds off ---
		write_len(1);
		rx_hold_arm <= 1'b1;
		for (i = 0; i < 48; i++)
			target_byte(($urandom_range(0, 1) == 0) ? pat_image[0] : BYTE_W'($urandom),
				1'b1);
		wait (rx_hold_done === 1'b1);
		settle();

		// --- random phases: new length, new pattern, a few searches each ---
		goal     = items_sent + RANDOM_ITEMS;
		phase_no = 0;
		while (items_sent < goal) begin
			r = $urandom_range(0, 29);
			if (phase_no == 0 || r == 0)
				v = PAT_MAX;
			else if (phase_no == 1 || r == 1)
				v = 1;
			else if (r == 2)
				v = $urandom_range(PAT_MAX + 1, 127);
			else if (r == 3)
				v = 0;
			else if (r <= 7)
				v = $urandom_range(9, 32);
			else
				v = $urandom_range(2, 8);
			write_len(v);
			// a narrow alphabet makes repeats and self-overlap likely
			narrow = ($urandom_range(0, 2) == 0);
			for (i = 0; i < cur_len; i++)
				write_pattern(i, narrow ? (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF)
					: BYTE_W'($urandom));
			searches = (cur_len > 16) ? 1 : $urandom_range(1, 4);
			repeat (searches) begin
				n = cur_len + $urandom_range(0, 12);
				if ($urandom_range(0, 5) == 0)
					n = $urandom_range(1, cur_len);
				run_search(n, $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
			end
			phase_no++;
		end

		// hold the sender until everything is back, then flag leftovers
		settle();
		drain_check <= 1'b1;
		@(posedge clk);
		drain_check <= 1'b0;
		@(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/ess_pkg.sv
rtl/ess_pattern_store.sv
rtl/ess_match_core.sv
rtl/exact_substring_search_unit.sv
tb/ess_search_checker.sv
tb/tb_exact_substring_search_unit.sv
